>>> src/rbi_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_pkg
// Types, codes and the shared fixed-point helper of the rigid body integrator.
// ----------------------------------------------------------------------------
package rbi_pkg;

    typedef enum logic [2:0] {
        FN_FORCE      = 3'd0,
        FN_TORQUE     = 3'd1,
        FN_IMPULSE    = 3'd2,
        FN_SPIN_IMP   = 3'd3,
        FN_SET_VEL    = 3'd4,
        FN_SET_POS    = 3'd5,
        FN_STEP       = 3'd6,
        FN_NOP        = 3'd7
    } func_t;

    typedef enum logic [2:0] {
        CFG_STEP_TIME = 3'd0,
        CFG_MASS      = 3'd1,
        CFG_INV_MASS  = 3'd2,
        CFG_INV_IX    = 3'd3,
        CFG_INV_IY    = 3'd4,
        CFG_INV_IZ    = 3'd5
    } cfg_idx_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } state_t;

    localparam logic signed [63:0] Q30_ONE = 64'sd1 << 30;

    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sd2147483647)
            r = 32'sh7fffffff;
        else if (v < -64'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

>>> src/rbi_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_mul
// Shared signed multiplier, rounds (a*b)/2^s to nearest, ties away from zero.
// One multiply per cycle, result registered.
// ----------------------------------------------------------------------------
module rbi_mul (
    input  logic               clk,
    input  logic signed [32:0] a,
    input  logic signed [32:0] b,
    input  logic        [5:0]  sh,
    output logic signed [63:0] p
);
    import rbi_pkg::*;

    logic               neg;
    logic        [32:0] ua;
    logic        [32:0] ub;
    logic        [65:0] prod;
    logic        [65:0] rnd;
    logic        [65:0] mag;
    logic signed [63:0] p_next;
    logic signed [63:0] p_reg;

    always_comb
    begin
        neg    = a[32] ^ b[32];
        ua     = a[32] ? 33'(-a) : 33'(a);
        ub     = b[32] ? 33'(-b) : 33'(b);
        prod   = 66'(ua) * 66'(ub);
        rnd    = prod + (66'd1 << (sh - 6'd1));
        mag    = rnd >> sh;
        p_next = neg ? -64'(mag) : 64'(mag);
    end

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

>>> src/rbi_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_core
// Step sequencer: microcode over one shared multiplier for momentum, position,
// rotation matrix, angular velocity, quaternion update and renormalization.
// ----------------------------------------------------------------------------
module rbi_core #(
    parameter int FRAC_BITS       = 16,
    parameter int NORM_ITERATIONS = 4
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic        [15:0]  dt,
    input  logic        [31:0]  inv_mass,
    input  logic        [31:0]  inv_i [3],
    input  logic signed [31:0]  fsum  [3],
    input  logic signed [31:0]  tsum  [3],
    input  logic signed [31:0]  isum  [3],
    input  logic signed [31:0]  ssum  [3],
    input  logic signed [31:0]  lmom_in [3],
    input  logic signed [31:0]  amom_in [3],
    input  logic signed [31:0]  pos_in  [3],
    input  logic signed [31:0]  q_in    [4],
    output logic signed [31:0]  lmom_out [3],
    output logic signed [31:0]  amom_out [3],
    output logic signed [31:0]  pos_out  [3],
    output logic signed [31:0]  q_out    [4],
    output logic                done
);
    import rbi_pkg::*;

    // Phases: each multiply phase issues one multiply per cycle, then consumes its products.
    typedef enum logic [3:0] {
        PH_MOM, PH_VEL, PH_POS, PH_RM, PH_U, PH_WK, PH_OM, PH_A, PH_C,
        PH_N2, PH_SCALE, PH_NT1, PH_NT2, PH_NT3, PH_OUT, PH_END
    } phase_t;

    logic               busy_reg, busy_next;
    phase_t             ph_reg, ph_next;
    logic        [3:0]  k_reg, k_next;
    logic               wait_reg, wait_next;
    logic        [5:0]  cnt_reg, cnt_next;
    logic        [3:0]  it_reg, it_next;

    logic signed [31:0] lm_reg [3], lm_next [3];
    logic signed [31:0] am_reg [3], am_next [3];
    logic signed [31:0] ps_reg [3], ps_next [3];
    logic signed [31:0] vl_reg [3], vl_next [3];
    logic signed [63:0] m_reg  [10], m_next [10];
    logic signed [31:0] r_reg  [9], r_next [9];
    logic signed [31:0] wk_reg [3], wk_next [3];
    logic signed [31:0] h_reg  [3], h_next [3];
    logic signed [63:0] c_reg  [4], c_next [4];
    logic signed [63:0] n2_reg, n2_next;
    logic signed [63:0] y_reg, y_next;
    logic signed [63:0] t_reg, t_next;
    logic signed [31:0] qo_reg [4], qo_next [4];

    logic signed [32:0] ma, mb;
    logic        [5:0]  msh;
    logic signed [63:0] mp;

    rbi_mul u_mul (.clk(clk), .a(ma), .b(mb), .sh(msh), .p(mp));

    logic signed [63:0] qw, qx, qy, qz;
    assign qw = 64'(q_in[0]);
    assign qx = 64'(q_in[1]);
    assign qy = 64'(q_in[2]);
    assign qz = 64'(q_in[3]);

    // rotation product list: xx yy zz xy xz yz wx wy wz
    logic [1:0] rpa, rpb;
    always_comb
    begin
        unique case (k_reg)
            4'd0: begin rpa = 2'd1; rpb = 2'd1; end
            4'd1: begin rpa = 2'd2; rpb = 2'd2; end
            4'd2: begin rpa = 2'd3; rpb = 2'd3; end
            4'd3: begin rpa = 2'd1; rpb = 2'd2; end
            4'd4: begin rpa = 2'd1; rpb = 2'd3; end
            4'd5: begin rpa = 2'd2; rpb = 2'd3; end
            4'd6: begin rpa = 2'd0; rpb = 2'd1; end
            4'd7: begin rpa = 2'd0; rpb = 2'd2; end
            default: begin rpa = 2'd0; rpb = 2'd3; end
        endcase
    end

    // c products: index k = 3*i + j, j=0 is the lead term
    logic signed [31:0] cpa, cpb;
    always_comb
    begin
        cpa = 32'sd0;
        cpb = 32'sd0;
        case (k_reg)
            4'd0: begin cpa = h_reg[0]; cpb = q_in[1]; end
            4'd1: begin cpa = h_reg[1]; cpb = q_in[2]; end
            4'd2: begin cpa = h_reg[2]; cpb = q_in[3]; end
            4'd3: begin cpa = q_in[0]; cpb = h_reg[0]; end
            4'd4: begin cpa = h_reg[1]; cpb = q_in[3]; end
            4'd5: begin cpa = h_reg[2]; cpb = q_in[2]; end
            4'd6: begin cpa = q_in[0]; cpb = h_reg[1]; end
            4'd7: begin cpa = h_reg[2]; cpb = q_in[1]; end
            4'd8: begin cpa = h_reg[0]; cpb = q_in[3]; end
            4'd9: begin cpa = q_in[0]; cpb = h_reg[2]; end
            4'd10: begin cpa = h_reg[0]; cpb = q_in[2]; end
            4'd11: begin cpa = h_reg[1]; cpb = q_in[1]; end
            default: ;
        endcase
    end

    // row (hi) and column of a 3x3 walk index
    function automatic logic [1:0] idx3(input logic [3:0] k, input logic hi);
        logic [1:0] q;
        logic [1:0] r;
        case (k) inside
            [4'd0:4'd2]: begin q = 2'd0; r = 2'(k); end
            [4'd3:4'd5]: begin q = 2'd1; r = 2'(k - 4'd3); end
            [4'd6:4'd8]: begin q = 2'd2; r = 2'(k - 4'd6); end
            default:     begin q = 2'd0; r = 2'd0; end
        endcase
        return hi ? q : r;
    endfunction

    // multiplier operand selection
    always_comb
    begin
        logic [1:0] ri, rj;
        ri  = idx3(k_reg, 1'b1);
        rj  = idx3(k_reg, 1'b0);
        ma  = 33'sd0;
        mb  = 33'sd0;
        msh = 6'd16;
        case (ph_reg)
            PH_MOM: begin
                ma = (k_reg < 4'd3) ? 33'(fsum[k_reg[1:0]]) : 33'(tsum[2'(k_reg - 4'd3)]);
                mb = 33'($signed({1'b0, dt}));
            end
            PH_VEL: begin
                ma = 33'(lm_reg[k_reg[1:0]]);
                mb = $signed({1'b0, inv_mass});
                msh = 6'(FRAC_BITS);
            end
            PH_POS: begin
                ma = 33'(vl_reg[k_reg[1:0]]);
                mb = 33'($signed({1'b0, dt}));
            end
            PH_RM: begin
                ma = 33'(q_in[rpa]);
                mb = 33'(q_in[rpb]);
                msh = 6'd30;
            end
            PH_U: begin
                ma = 33'(r_reg[4'(rj) * 4'd3 + 4'(ri)]);
                mb = 33'(am_reg[rj]);
                msh = 6'd30;
            end
            PH_WK: begin
                ma = 33'(sat32(m_reg[k_reg]));
                mb = $signed({1'b0, inv_i[k_reg[1:0]]});
                msh = 6'(FRAC_BITS);
            end
            PH_OM: begin
                ma = 33'(r_reg[4'(ri) * 4'd3 + 4'(rj)]);
                mb = 33'(wk_reg[rj]);
                msh = 6'd30;
            end
            PH_A: begin
                ma = 33'(sat32(m_reg[k_reg]));
                mb = 33'($signed({1'b0, dt}));
            end
            PH_C: begin
                ma = 33'(cpa);
                mb = 33'(cpb);
                msh = 6'd30;
            end
            PH_N2: begin
                ma = c_reg[k_reg[1:0]][32:0];
                mb = c_reg[k_reg[1:0]][32:0];
                msh = 6'd30;
            end
            PH_NT1: begin
                ma = y_reg[32:0];
                mb = y_reg[32:0];
                msh = 6'd30;
            end
            PH_NT2: begin
                ma = n2_reg[32:0];
                mb = t_reg[32:0];
                msh = 6'd30;
            end
            PH_NT3: begin
                ma = y_reg[32:0];
                mb = 33'(3 * Q30_ONE - t_reg);
                msh = 6'd31;
            end
            PH_OUT: begin
                ma = c_reg[k_reg[1:0]][32:0];
                mb = y_reg[32:0];
                msh = 6'd30;
            end
            default: ;
        endcase
    end

    // number of multiplies issued per phase
    function automatic logic [3:0] nmul(input phase_t p);
        logic [3:0] n;
        case (p)
            PH_MOM: n = 4'd6;
            PH_RM, PH_U, PH_OM: n = 4'd9;
            PH_C: n = 4'd12;
            PH_N2, PH_OUT: n = 4'd4;
            PH_NT1, PH_NT2, PH_NT3: n = 4'd1;
            default: n = 4'd3;
        endcase
        return n;
    endfunction

    always_comb
    begin
        logic signed [63:0] s;
        logic               any;
        logic               inc;
        busy_next = busy_reg;
        ph_next   = ph_reg;
        k_next    = k_reg;
        wait_next = wait_reg;
        cnt_next  = cnt_reg;
        it_next   = it_reg;
        lm_next   = lm_reg;
        am_next   = am_reg;
        ps_next   = ps_reg;
        vl_next   = vl_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        wk_next   = wk_reg;
        h_next    = h_reg;
        c_next    = c_reg;
        n2_next   = n2_reg;
        y_next    = y_reg;
        t_next    = t_reg;
        qo_next   = qo_reg;
        s         = 64'sd0;
        any       = 1'b0;
        inc       = 1'b0;
        if (start)
        begin
            busy_next = 1'b1;
            ph_next   = PH_MOM;
            k_next    = 4'd0;
            wait_next = 1'b0;
            lm_next   = lmom_in;
            am_next   = amom_in;
            ps_next   = pos_in;
        end
        else if (busy_reg)
        begin
            if (wait_reg)
            begin
                // products of the phase are complete in m_reg
                wait_next = 1'b0;
                k_next    = 4'd0;
                unique case (ph_reg)
                    PH_MOM: begin
                        for (int i = 0; i < 3; i++)
                        begin
                            lm_next[i] = sat32(64'(lm_reg[i]) + 64'(isum[i]) + m_reg[i]);
                            am_next[i] = sat32(64'(am_reg[i]) + 64'(ssum[i]) + m_reg[i+3]);
                        end
                        ph_next = PH_VEL;
                    end
                    PH_VEL: begin
                        for (int i = 0; i < 3; i++)
                            vl_next[i] = sat32(m_reg[i]);
                        ph_next = PH_POS;
                    end
                    PH_POS: begin
                        for (int i = 0; i < 3; i++)
                            ps_next[i] = sat32(64'(ps_reg[i]) + m_reg[i]);
                        ph_next = PH_RM;
                    end
                    PH_RM: begin
                        r_next[0] = sat32(Q30_ONE - 2 * (m_reg[1] + m_reg[2]));
                        r_next[1] = sat32(2 * (m_reg[3] - m_reg[8]));
                        r_next[2] = sat32(2 * (m_reg[4] + m_reg[7]));
                        r_next[3] = sat32(2 * (m_reg[3] + m_reg[8]));
                        r_next[4] = sat32(Q30_ONE - 2 * (m_reg[0] + m_reg[2]));
                        r_next[5] = sat32(2 * (m_reg[5] - m_reg[6]));
                        r_next[6] = sat32(2 * (m_reg[4] - m_reg[7]));
                        r_next[7] = sat32(2 * (m_reg[5] + m_reg[6]));
                        r_next[8] = sat32(Q30_ONE - 2 * (m_reg[0] + m_reg[1]));
                        ph_next = PH_U;
                    end
                    PH_U, PH_OM: begin
                        for (int i = 0; i < 3; i++)
                            m_next[i] = m_reg[3*i] + m_reg[3*i+1] + m_reg[3*i+2];
                        ph_next = (ph_reg == PH_U) ? PH_WK : PH_A;
                    end
                    PH_WK: begin
                        for (int i = 0; i < 3; i++)
                            wk_next[i] = sat32(m_reg[i]);
                        ph_next = PH_OM;
                    end
                    PH_A: begin
                        for (int i = 0; i < 3; i++)
                            h_next[i] = sat32(64'(sat32(m_reg[i])) <<< (29 - FRAC_BITS));
                        ph_next = PH_C;
                    end
                    PH_C: begin
                        c_next[0] = 64'(sat32(qw - m_reg[0] - m_reg[1] - m_reg[2]));
                        // m_reg holds products 0..9; 10,11 kept in t_reg, n2_reg
                        c_next[1] = 64'(sat32(qx + m_reg[3] + m_reg[4] - m_reg[5]));
                        c_next[2] = 64'(sat32(qy + m_reg[6] + m_reg[7] - m_reg[8]));
                        c_next[3] = 64'(sat32(qz + m_reg[9] + t_reg - n2_reg));
                        any = (c_next[0] != 0) || (c_next[1] != 0) ||
                              (c_next[2] != 0) || (c_next[3] != 0);
                        if (!any)
                        begin
                            qo_next[0] = 32'(Q30_ONE);
                            qo_next[1] = 32'sd0;
                            qo_next[2] = 32'sd0;
                            qo_next[3] = 32'sd0;
                            ph_next    = PH_END;
                        end
                        else
                        begin
                            ph_next = PH_N2;
                        end
                        cnt_next = 6'd0;
                        it_next  = 4'd0;
                    end
                    PH_N2: begin
                        s = m_reg[0] + m_reg[1] + m_reg[2] + m_reg[3];
                        n2_next = s;
                        ph_next = PH_N2;
                        if (cnt_reg[5] == 1'b0 && cnt_reg < 6'd8 && it_reg == 4'd0 &&
                            s >= 2 * Q30_ONE)
                        begin
                            for (int i = 0; i < 4; i++)
                                c_next[i] = (c_reg[i] < 0) ? -((-c_reg[i]) >>> 1)
                                                           : (c_reg[i] >>> 1);
                            cnt_next = cnt_reg + 6'd1;
                        end
                        else if (it_reg == 4'd0 && s >= 2 * Q30_ONE)
                        begin
                            ph_next = PH_SCALE;
                        end
                        else if (s < Q30_ONE / 2 && (it_reg != 4'd1 || cnt_reg < 6'd32))
                        begin
                            if (it_reg == 4'd0)
                            begin
                                it_next  = 4'd1;
                                cnt_next = 6'd0;
                            end
                            else
                            begin
                                cnt_next = cnt_reg + 6'd1;
                            end
                            inc = (it_reg == 4'd0) || (cnt_reg + 6'd1 < 6'd33);
                            if (it_reg == 4'd0 || cnt_reg < 6'd32)
                                for (int i = 0; i < 4; i++)
                                    c_next[i] = c_reg[i] <<< 1;
                            if (!inc)
                                ph_next = PH_SCALE;
                        end
                        else
                        begin
                            ph_next = PH_SCALE;
                        end
                    end
                    default: ;
                endcase
                if (ph_reg == PH_SCALE || ph_reg == PH_NT1 || ph_reg == PH_NT2 ||
                    ph_reg == PH_NT3 || ph_reg == PH_OUT)
                begin
                    unique case (ph_reg)
                        PH_NT1: begin
                            t_next  = 64'(sat32(m_reg[0]));
                            ph_next = PH_NT2;
                        end
                        PH_NT2: begin
                            t_next  = 64'(sat32(m_reg[0]));
                            ph_next = PH_NT3;
                        end
                        PH_NT3: begin
                            y_next  = 64'(sat32(m_reg[0]));
                            it_next = it_reg + 4'd1;
                            ph_next = (it_reg + 4'd1 == 4'(NORM_ITERATIONS)) ? PH_OUT
                                                                            : PH_NT1;
                        end
                        PH_OUT: begin
                            for (int i = 0; i < 4; i++)
                                qo_next[i] = sat32(m_reg[i]);
                            ph_next = PH_END;
                        end
                        default: ;
                    endcase
                end
            end
            else if (ph_reg == PH_SCALE)
            begin
                y_next  = Q30_ONE;
                it_next = 4'd0;
                ph_next = PH_NT1;
            end
            else if (ph_reg == PH_END)
            begin
                busy_next = 1'b0;
                ph_next   = PH_MOM;
            end
            else
            begin
                // capture the product issued in the cycle before
                if (k_reg != 4'd0)
                begin
                    if (k_reg - 4'd1 < 4'd10)
                        m_next[k_reg - 4'd1] = mp;
                    if (ph_reg == PH_C && k_reg == 4'd11)
                        t_next = mp;
                end
                if (k_reg == nmul(ph_reg))
                begin
                    wait_next = 1'b1;
                    if (ph_reg == PH_C)
                        n2_next = mp;
                    else
                        m_next[k_reg - 4'd1] = mp;
                end
                else
                begin
                    k_next = k_reg + 4'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            ph_reg   <= PH_MOM;
            k_reg    <= 4'd0;
            wait_reg <= 1'b0;
            cnt_reg  <= 6'd0;
            it_reg   <= 4'd0;
        end
        else
        begin
            busy_reg <= busy_next;
            ph_reg   <= ph_next;
            k_reg    <= k_next;
            wait_reg <= wait_next;
            cnt_reg  <= cnt_next;
            it_reg   <= it_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lm_reg <= lm_next;
        am_reg <= am_next;
        ps_reg <= ps_next;
        vl_reg <= vl_next;
        m_reg  <= m_next;
        r_reg  <= r_next;
        wk_reg <= wk_next;
        h_reg  <= h_next;
        c_reg  <= c_next;
        n2_reg <= n2_next;
        y_reg  <= y_next;
        t_reg  <= t_next;
        qo_reg <= qo_next;
    end

    assign lmom_out = lm_reg;
    assign amom_out = am_reg;
    assign pos_out  = ps_reg;
    assign q_out    = qo_reg;
    assign done     = busy_reg && (ph_reg == PH_END);

endmodule

>>> src/rigid_body_integrator.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rigid_body_integrator
// Fixed-point rigid body integrator: accumulate, set and step items, each
// answered with the current pose.
// ----------------------------------------------------------------------------
// channel | direction | beat
// in      | input     | func, vec_x/y/z
// out     | output    | pos_x/y/z, quat_w/x/y/z
// cfg     | input     | cfg_index, cfg_data
//
// Accumulate, set and unused items have their result valid the cycle after accept.
// A step runs through one shared multiplier; each norm halving or doubling pass
// adds to its run time, and an all-zero updated quaternion skips renormalization
// and yields the identity quaternion.
// Reset restores the identity pose, clears momenta and accumulated inputs, and loads default configuration.
// in_ready stays low while a result waits on out_ready.
// ----------------------------------------------------------------------------
module rigid_body_integrator #(
    parameter int FRAC_BITS       = 16,
    parameter int NORM_ITERATIONS = 4
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         func,
    input  logic signed [31:0] vec_x,
    input  logic signed [31:0] vec_y,
    input  logic signed [31:0] vec_z,
    output logic               out_valid,
    input  logic               out_ready,
    output logic signed [31:0] pos_x,
    output logic signed [31:0] pos_y,
    output logic signed [31:0] pos_z,
    output logic signed [31:0] quat_w,
    output logic signed [31:0] quat_x,
    output logic signed [31:0] quat_y,
    output logic signed [31:0] quat_z,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import rbi_pkg::*;

    state_t             state_reg, state_next;
    logic [15:0]        dt_reg;
    logic [31:0]        mass_reg, imass_reg;
    logic [31:0]        ii_reg [3];
    logic signed [31:0] pos_reg [3], pos_next [3];
    logic signed [31:0] q_reg [4], q_next [4];
    logic signed [31:0] lm_reg [3], lm_next [3];
    logic signed [31:0] am_reg [3], am_next [3];
    logic signed [31:0] f_reg [3], f_next [3];
    logic signed [31:0] t_reg [3], t_next [3];
    logic signed [31:0] i_reg [3], i_next [3];
    logic signed [31:0] s_reg [3], s_next [3];
    logic               start;
    logic               done;
    logic signed [31:0] c_lm [3], c_am [3], c_pos [3], c_q [4];
    logic signed [31:0] v [3];
    logic               acc;

    assign v[0] = vec_x;
    assign v[1] = vec_y;
    assign v[2] = vec_z;

    assign acc       = in_valid && in_ready;
    assign in_ready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign start     = acc && (func_t'(func) == FN_STEP);

    rbi_core #(.FRAC_BITS(FRAC_BITS), .NORM_ITERATIONS(NORM_ITERATIONS)) u_core (
        .clk(clk), .rst_n(rst_n), .start(start), .dt(dt_reg), .inv_mass(imass_reg),
        .inv_i(ii_reg), .fsum(f_reg), .tsum(t_reg), .isum(i_reg), .ssum(s_reg),
        .lmom_in(lm_reg), .amom_in(am_reg), .pos_in(pos_reg), .q_in(q_reg),
        .lmom_out(c_lm), .amom_out(c_am), .pos_out(c_pos), .q_out(c_q), .done(done)
    );

    // set-velocity product: 32x32 on a set-velocity item only
    function automatic logic signed [31:0] mom_of(input logic signed [31:0] a,
                                                  input logic [31:0] m);
        logic               ng;
        logic [31:0]        ua;
        logic [63:0]        pr;
        logic signed [64:0] r;
        ng = a[31];
        ua = ng ? 32'(-a) : 32'(a);
        pr = (64'(ua) * 64'(m) + (64'd1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        r  = ng ? -65'(pr) : 65'(pr);
        return (r > 65'sd2147483647) ? 32'sh7fffffff :
               (r < -65'sd2147483648) ? 32'sh80000000 : r[31:0];
    endfunction

    always_comb
    begin
        unique case (state_reg)
            ST_IDLE: state_next = !acc ? ST_IDLE :
                                  (func_t'(func) == FN_STEP) ? ST_RUN : ST_DONE;
            ST_RUN:  state_next = done ? ST_DONE : ST_RUN;
            ST_DONE: state_next = out_ready ? ST_IDLE : ST_DONE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        q_next   = q_reg;
        lm_next  = lm_reg;
        am_next  = am_reg;
        f_next   = f_reg;
        t_next   = t_reg;
        i_next   = i_reg;
        s_next   = s_reg;
        if (acc)
        begin
            for (int i = 0; i < 3; i++)
            begin
                unique case (func_t'(func))
                    FN_FORCE:    f_next[i] = sat32(64'(f_reg[i]) + 64'(v[i]));
                    FN_TORQUE:   t_next[i] = sat32(64'(t_reg[i]) + 64'(v[i]));
                    FN_IMPULSE:  i_next[i] = sat32(64'(i_reg[i]) + 64'(v[i]));
                    FN_SPIN_IMP: s_next[i] = sat32(64'(s_reg[i]) + 64'(v[i]));
                    FN_SET_VEL:  lm_next[i] = mom_of(v[i], mass_reg);
                    FN_SET_POS:  pos_next[i] = v[i];
                    default: ;
                endcase
            end
        end
        if (state_reg == ST_RUN && done)
        begin
            pos_next = c_pos;
            q_next   = c_q;
            lm_next  = c_lm;
            am_next  = c_am;
            for (int i = 0; i < 3; i++)
            begin
                f_next[i] = 32'sd0;
                t_next[i] = 32'sd0;
                i_next[i] = 32'sd0;
                s_next[i] = 32'sd0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            dt_reg    <= 16'd1092;
            mass_reg  <= 32'd65536;
            imass_reg <= 32'd65536;
            for (int i = 0; i < 3; i++)
            begin
                ii_reg[i]  <= 32'd65536;
                pos_reg[i] <= 32'sd0;
                lm_reg[i]  <= 32'sd0;
                am_reg[i]  <= 32'sd0;
                f_reg[i]   <= 32'sd0;
                t_reg[i]   <= 32'sd0;
                i_reg[i]   <= 32'sd0;
                s_reg[i]   <= 32'sd0;
            end
            q_reg[0] <= 32'(Q30_ONE);
            q_reg[1] <= 32'sd0;
            q_reg[2] <= 32'sd0;
            q_reg[3] <= 32'sd0;
        end
        else
        begin
            state_reg <= state_next;
            pos_reg   <= pos_next;
            q_reg     <= q_next;
            lm_reg    <= lm_next;
            am_reg    <= am_next;
            f_reg     <= f_next;
            t_reg     <= t_next;
            i_reg     <= i_next;
            s_reg     <= s_next;
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    CFG_STEP_TIME: dt_reg    <= cfg_data[15:0];
                    CFG_MASS:      mass_reg  <= cfg_data;
                    CFG_INV_MASS:  imass_reg <= cfg_data;
                    CFG_INV_IX:    ii_reg[0] <= cfg_data;
                    CFG_INV_IY:    ii_reg[1] <= cfg_data;
                    CFG_INV_IZ:    ii_reg[2] <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    assign out_valid = (state_reg == ST_DONE);
    assign pos_x  = pos_reg[0];
    assign pos_y  = pos_reg[1];
    assign pos_z  = pos_reg[2];
    assign quat_w = q_reg[0];
    assign quat_x = q_reg[1];
    assign quat_y = q_reg[2];
    assign quat_z = q_reg[3];

endmodule

>>> src/rbi_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbi_checker
// Port-level checks of the integrator handshakes.
// ----------------------------------------------------------------------------
module rbi_checker (
    input logic clk,
    input logic rst_n,
    input logic in_valid,
    input logic in_ready,
    input logic out_valid,
    input logic out_ready,
    input logic signed [31:0] pos_x
);
    a_one_outstanding: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    a_out_holds: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(pos_x))
        else $error("result dropped or changed");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready) else $error("second item taken");

    a_ready_after: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready |=> in_ready) else $error("not ready after result");
endmodule

bind rigid_body_integrator rbi_checker u_rbi_checker (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_ready(in_ready),
    .out_valid(out_valid), .out_ready(out_ready), .pos_x(pos_x)
);
